// File: hdl/date_difference_days_core_defines.svh
// Assertion macros used by the checker file of the date difference core.
`ifndef DATE_DIFFERENCE_DAYS_CORE_DEFINES_SVH
`define DATE_DIFFERENCE_DAYS_CORE_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define DDD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DDD_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ddd_pkg.sv
`timescale 1ns / 1ps

package ddd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ORD_W   = 23;
  localparam int COUNT_W = 23;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 23'd4194303;

  // floor(q / 25) for q below 43690 is (q * 5243) >> 17.
  localparam logic [12:0] DIV25_MUL   = 13'd5243;
  localparam int          DIV25_SHIFT = 17;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [ORD_W-1:0] ordinal;
    logic             ok;
  } lane_res_t;

  // floor(y / 100) as floor(floor(y / 4) / 25).
  function automatic logic [7:0] div100(input logic [YEAR_W-1:0] y);
    logic [24:0] prod;
    prod = {13'd0, y[YEAR_W-1:2]} * {12'd0, DIV25_MUL};
    return prod[DIV25_SHIFT +: 8];
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m, input logic leap);
    logic [8:0] off;
    case (m)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off + {8'd0, leap && (m > 4'd2)};
  endfunction

  // Length of month m; zero for a month number outside the calendar.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                               n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:            n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                       n = 5'd31;
      default:                            n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/date_difference_days_core.sv
`timescale 1ns / 1ps
// Signed Gregorian day distance between a start date and an end date.
// Input channel s_*: one item per handshake carrying both dates in s_tdata
// and the include-end flag in s_tuser. Output channel m_*: one item per
// input item, the signed day count in m_tdata and the invalid flag in m_tuser.
// A bad month or day raises the invalid flag and gives a count of zero;
// magnitudes above 4194303 saturate.
// Two identical lanes turn the dates into day ordinals in two stages (a
// quotient by one hundred, then the year, month and day sums); a merge stage
// subtracts them into the output register.
// An item passes three register stages, the two lane stages and then the
// output register. Throughput is one item per cycle while m_tready does not
// stall the output.
// Each stage fills whenever it is empty, so the pipeline absorbs up to three
// items while m_tready is low; s_tready drops only when all stages are full.
// Reset (rst, synchronous, active high) empties the pipeline and lowers
// m_tvalid; no item in flight survives it.
module date_difference_days_core import ddd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18],
  // end_year[36:23], end_month[40:37], end_day[45:41], zeros[47:46]
  input  logic [47:0] s_tdata,
  // include_end[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // day_count[22:0], zero[23]
  output logic [23:0] m_tdata,
  // date_invalid[0]
  output logic        m_tuser
);

  logic v1;
  logic v2;
  logic incl1;
  logic incl2;
  logic rdy1;
  logic rdy2;
  logic rdy3;

  date_t              start_dt;
  date_t              end_dt;
  lane_res_t          start_res;
  lane_res_t          end_res;
  logic [COUNT_W-1:0] day_count;

  assign start_dt = '{year: s_tdata[13:0], month: s_tdata[17:14], day: s_tdata[22:18]};
  assign end_dt   = '{year: s_tdata[36:23], month: s_tdata[40:37], day: s_tdata[45:41]};

  assign rdy3     = !m_tvalid || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) incl1 <= s_tuser;
    if (rdy2) incl2 <= incl1;
  end

  ddd_lane u_lane_start (
    .clk (clk),
    .en1 (rdy1),
    .en2 (rdy2),
    .dt  (start_dt),
    .res (start_res)
  );

  ddd_lane u_lane_end (
    .clk (clk),
    .en1 (rdy1),
    .en2 (rdy2),
    .dt  (end_dt),
    .res (end_res)
  );

  ddd_merge u_merge (
    .clk          (clk),
    .en           (rdy3),
    .start_res    (start_res),
    .end_res      (end_res),
    .include_end  (incl2),
    .day_count    (day_count),
    .date_invalid (m_tuser)
  );

  assign m_tdata = {1'b0, day_count};

endmodule

// File: hdl/ddd_lane.sv
`timescale 1ns / 1ps

module ddd_lane import ddd_pkg::*; (
  input  logic      clk,
  input  logic      en1,
  input  logic      en2,
  input  date_t     dt,
  output lane_res_t res
);

  logic [YEAR_W-1:0]  y1;
  logic [MONTH_W-1:0] m1;
  logic [DAY_W-1:0]   d1;
  logic [7:0]         q100;

  logic [YEAR_W-1:0]  hundreds;
  logic               is100;
  logic               is400;
  logic               leap;
  logic [12:0]        ceil4;
  logic [7:0]         ceil100;
  logic [5:0]         ceil400;
  logic [ORD_W-1:0]   year_days;
  logic [ORD_W-1:0]   ordinal_next;
  logic [DAY_W-1:0]   dim;
  logic               ok_next;

  // Stage one: registers the date and the quotient by one hundred.
  always_ff @(posedge clk) begin
    if (en1) begin
      y1   <= dt.year;
      m1   <= dt.month;
      d1   <= dt.day;
      q100 <= div100(dt.year);
    end
  end

  always_comb begin
    hundreds = {6'd0, q100} * 14'd100;
    is100    = (hundreds == y1);
    is400    = is100 && (q100[1:0] == 2'd0);
    leap     = is400 || (!is100 && (y1[1:0] == 2'd0));
    // The top year of the field rounds up to 4096, one bit beyond y1 >> 2.
    ceil4    = {1'b0, y1[YEAR_W-1:2]} + {12'd0, y1[1:0] != 2'd0};
    ceil100  = q100 + {7'd0, !is100};
    ceil400  = q100[7:2] + {5'd0, !is400};
    year_days = ({9'd0, y1} * 23'd365) + {10'd0, ceil4} - {15'd0, ceil100}
              + {17'd0, ceil400};
    ordinal_next = year_days + {14'd0, month_offset(m1, leap)} + {18'd0, d1} - 23'd1;
    dim      = month_days(m1, leap);
    ok_next  = (dim != 5'd0) && (d1 != 5'd0) && (d1 <= dim);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res.ordinal <= ordinal_next;
      res.ok      <= ok_next;
    end
  end

endmodule

// File: hdl/ddd_merge.sv
`timescale 1ns / 1ps

module ddd_merge import ddd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  lane_res_t          start_res,
  input  lane_res_t          end_res,
  input  logic               include_end,
  output logic [COUNT_W-1:0] day_count,
  output logic               date_invalid
);

  logic               neg;
  logic [ORD_W-1:0]   mag;
  logic [ORD_W:0]     mag_inc;
  logic [COUNT_W-1:0] mag_sat;
  logic [COUNT_W-1:0] count_next;
  logic               invalid_next;

  always_comb begin
    neg      = end_res.ordinal < start_res.ordinal;
    mag      = neg ? (start_res.ordinal - end_res.ordinal)
                   : (end_res.ordinal - start_res.ordinal);
    mag_inc  = {1'b0, mag} + {{ORD_W{1'b0}}, include_end};
    mag_sat  = (mag_inc > {1'b0, COUNT_MAX}) ? COUNT_MAX : mag_inc[COUNT_W-1:0];
    invalid_next = !(start_res.ok && end_res.ok);
    if (invalid_next) begin
      count_next = '0;
    end else begin
      count_next = neg ? (~mag_sat + 23'd1) : mag_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_count    <= count_next;
      date_invalid <= invalid_next;
    end
  end

endmodule

// File: hdl/ddd_checker.sv
`timescale 1ns / 1ps
`include "date_difference_days_core_defines.svh"

module ddd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // An invalid date pair always reports a zero count.
  `DDD_ASSERT(a_invalid_zero, m_tvalid && m_tuser |-> m_tdata == 24'd0, "invalid item with nonzero count")

  // Saturation keeps the count symmetric: the most negative code never appears.
  `DDD_ASSERT(a_sat_range, m_tvalid |-> (m_tdata[22:0] != 23'h400000) && !m_tdata[23], "count out of range")

  // A stalled result stays in place.
  `DDD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled item changed")

  // No result is shown in the cycle after reset.
  `DDD_ASSERT_RST(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid after reset")

endmodule

bind date_difference_days_core ddd_checker u_ddd_checker (.*);
